[hdl/apdf_pkg.sv]
// ----------------------------------------------------------------------------
// APDU deframer package
// Shared types, codes and defaults for the HID APDU response deframer.
// ----------------------------------------------------------------------------
package apdf_pkg;

  localparam int APDF_PACKET_BYTES   = 64;
  localparam int APDF_FIRST_CAPACITY = 57;
  localparam int APDF_NEXT_CAPACITY  = 59;
  localparam int APDF_QUEUE_DEPTH    = 4;

  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] SW_OK          = 16'h9000;
  localparam logic [15:0] CHANNEL_ID_RST = 16'h0101;
  localparam logic [7:0]  APDU_TAG_RST   = 8'h05;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_CHANNEL_ID = 1'b0,
    CFG_APDU_TAG   = 1'b1
  } cfg_idx_t;

  // Request types on the input channel
  typedef enum logic [1:0] {
    REQ_BYTE    = 2'd0,
    REQ_TIMEOUT = 2'd1,
    REQ_FAIL    = 2'd2,
    REQ_NONE    = 2'd3
  } req_type_t;

  // Classified item kinds held in the queue
  typedef enum logic [1:0] {
    ITEM_BYTE    = 2'd0,
    ITEM_TIMEOUT = 2'd1,
    ITEM_FAIL    = 2'd2
  } item_kind_t;

  typedef enum logic [2:0] {
    RC_BUSY      = 3'd0,
    RC_OK        = 3'd1,
    RC_STATUS    = 3'd2,
    RC_SHORT     = 3'd3,
    RC_TIMEOUT   = 3'd4,
    RC_READ_FAIL = 3'd5
  } result_code_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [7:0]  rx_byte;
    logic        start;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  typedef struct packed {
    logic [7:0]   data_byte;
    logic         data_valid;
    logic         last;
    result_code_t result_code;
    logic [15:0]  status_word;
    logic [15:0]  response_length;
  } result_t;

endpackage

[hdl/apdf_in_if.sv]
// ----------------------------------------------------------------------------
// APDU deframer input channel
// Valid/ready channel carrying one received byte or a read event.
// ----------------------------------------------------------------------------
interface apdf_in_if import apdf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] rx_byte;
  logic       packet_start;

  modport source (output valid, output req_type, output rx_byte, output packet_start,
                  input ready);
  modport sink   (input valid, input req_type, input rx_byte, input packet_start,
                  output ready);
endinterface

[hdl/apdf_out_if.sv]
// ----------------------------------------------------------------------------
// APDU deframer result channel
// Valid/ready channel carrying one deframed payload byte or status result.
// ----------------------------------------------------------------------------
interface apdf_out_if import apdf_pkg::*; ();
  logic         valid;
  logic         ready;
  logic [7:0]   data_byte;
  logic         data_valid;
  logic         last;
  logic [2:0]   result_code;
  logic [15:0]  status_word;
  logic [15:0]  response_length;

  modport source (output valid, output data_byte, output data_valid, output last,
                  output result_code, output status_word, output response_length,
                  input ready);
  modport sink   (input valid, input data_byte, input data_valid, input last,
                  input result_code, input status_word, input response_length,
                  output ready);
endinterface

[hdl/apdu_packet_deframer_unit.sv]
// ----------------------------------------------------------------------------
// APDU packet deframer
// Strips HID report headers from a received APDU response and streams out the
// payload bytes, ending with the status word and a result code.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Transfer carries                                  Handshake
//  -------  ---  ------------------------------------------------  ---------
//  in_ch    in   req_type, rx_byte, packet_start                   valid/ready
//  out_ch   out  data_byte, data_valid, last, result_code,         valid/ready
//                status_word, response_length
//  cfg_*    in   cfg_index, cfg_wdata (channel_id, apdu_tag)        cfg_we
//
//  One input transfer per clock is sustained while the queue has room; the core
//  retires one queued item per cycle while out_ch does not stall. Each result is
//  registered on its way to out_ch: the queue entry is written at the transfer
//  edge, then the core's result register when the core takes that entry.
//  Reset is synchronous; no clearing pass is needed.
//  When out_ch stalls, the core holds its result register and the queue of
//  QUEUE_DEPTH entries absorbs input; in_ch.ready drops only when it is full.
//
module apdu_packet_deframer_unit import apdf_pkg::*; #(
  parameter int PACKET_BYTES   = APDF_PACKET_BYTES,
  parameter int FIRST_CAPACITY = APDF_FIRST_CAPACITY,
  parameter int NEXT_CAPACITY  = APDF_NEXT_CAPACITY,
  parameter int QUEUE_DEPTH    = APDF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  apdf_in_if.sink               in_ch,
  apdf_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  q_push_t q_push;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;

  // Front end: classify each request and drop unused codes before queuing
  apdf_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push)
  );

  // Queue: lets the front keep taking transfers while the result side stalls
  apdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (q_pop),
    .full   (q_full),
    .head   (q_head)
  );

  // Core: header checks, sequence tracking, payload and completion results
  apdf_core #(
    .PACKET_BYTES   (PACKET_BYTES),
    .FIRST_CAPACITY (FIRST_CAPACITY),
    .NEXT_CAPACITY  (NEXT_CAPACITY)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .pop       (q_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_ch    (out_ch)
  );

endmodule

[hdl/apdf_front.sv]
// ----------------------------------------------------------------------------
// APDU deframer front end
// Accepts input transfers, classifies them and pushes them into the queue.
// ----------------------------------------------------------------------------
module apdf_front import apdf_pkg::*; (
  apdf_in_if.sink  in_ch,
  input  logic     q_full,
  output q_push_t  q_push
);

  logic take;

  assign in_ch.ready = !q_full;
  assign take        = in_ch.valid && !q_full;

  always_comb begin
    q_push               = '0;
    q_push.entry.rx_byte = in_ch.rx_byte;
    q_push.entry.start   = in_ch.packet_start;
    q_push.entry.kind    = ITEM_BYTE;
    case (in_ch.req_type)
      REQ_BYTE: begin
        q_push.push = take;
      end
      REQ_TIMEOUT: begin
        q_push.entry.kind = ITEM_TIMEOUT;
        q_push.push       = take;
      end
      REQ_FAIL: begin
        q_push.entry.kind = ITEM_FAIL;
        q_push.push       = take;
      end
      default: begin
        // drop unused request codes: accepted, no effect
        q_push.push = 1'b0;
      end
    endcase
  end

endmodule

[hdl/apdf_queue.sv]
// ----------------------------------------------------------------------------
// APDU deframer item queue
// Small register FIFO that decouples the front end from the deframer core.
// ----------------------------------------------------------------------------
module apdf_queue import apdf_pkg::*; #(
  parameter int DEPTH = APDF_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  q_push_t q_push,
  input  logic    pop,
  output logic    full,
  output q_head_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);

  q_entry_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_push.push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({q_push.push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      mem_r[wr_ptr_r] <= q_push.entry;
    end
  end

endmodule

[hdl/apdf_core.sv]
// ----------------------------------------------------------------------------
// APDU deframer core
// Header checks, length tracking, payload emission and the result register.
// ----------------------------------------------------------------------------
module apdf_core import apdf_pkg::*; #(
  parameter int PACKET_BYTES   = APDF_PACKET_BYTES,
  parameter int FIRST_CAPACITY = APDF_FIRST_CAPACITY,
  parameter int NEXT_CAPACITY  = APDF_NEXT_CAPACITY
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  q_head_t               head,
  output logic                  pop,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  apdf_out_if.source            out_ch
);

  localparam int POS_W = $clog2(PACKET_BYTES);
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(PACKET_BYTES - 1);
  localparam logic [POS_W-1:0] HDR_FIRST = POS_W'(7);
  localparam logic [POS_W-1:0] HDR_NEXT  = POS_W'(5);
  localparam logic [7:0]       CAP_FIRST = 8'(FIRST_CAPACITY);
  localparam logic [7:0]       CAP_NEXT  = 8'(NEXT_CAPACITY);

  logic [15:0]      chan_r;
  logic [7:0]       tag_r;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      seq_r, seq_nxt;
  logic [15:0]      total_r, total_nxt;
  logic [15:0]      rcvd_r, rcvd_nxt;
  logic             rej_r, rej_nxt;
  logic [7:0]       hi_r, hi_nxt;
  logic [15:0]      trail_r, trail_nxt;

  logic             out_valid_r, out_valid_nxt;
  result_t          out_r, out_nxt;

  logic             fire;
  logic             emit;
  result_t          res;
  logic [POS_W-1:0] pos_c;
  logic [POS_W-1:0] offset;
  logic             rej_c;
  logic             seq0;
  logic [7:0]       cap;
  logic [7:0]       b;
  logic [15:0]      word;
  logic [15:0]      rcvd_inc;
  logic [15:0]      trail_sh;

  assign b        = head.entry.rx_byte;
  assign word     = {hi_r, b};
  assign rcvd_inc = rcvd_r + 16'd1;
  assign trail_sh = {trail_r[7:0], b};
  assign seq0     = (seq_r == 16'd0);
  assign cap      = seq0 ? CAP_FIRST : CAP_NEXT;

  assign fire = head.valid && (!out_valid_r || out_ch.ready);
  assign pop  = fire;

  always_comb begin
    pos_nxt   = pos_r;
    seq_nxt   = seq_r;
    total_nxt = total_r;
    rcvd_nxt  = rcvd_r;
    rej_nxt   = rej_r;
    hi_nxt    = hi_r;
    trail_nxt = trail_r;
    emit      = 1'b0;
    res       = '0;
    rej_c     = rej_r;
    pos_c     = pos_r;
    offset    = pos_r - (seq0 ? HDR_FIRST : HDR_NEXT);

    if (fire) begin
      case (head.entry.kind)
        ITEM_TIMEOUT, ITEM_FAIL: begin
          emit                = 1'b1;
          res.last            = 1'b1;
          res.result_code     = (head.entry.kind == ITEM_TIMEOUT) ? RC_TIMEOUT
                                                                  : RC_READ_FAIL;
          res.response_length = total_r;
          seq_nxt   = '0;
          rcvd_nxt  = '0;
          total_nxt = '0;
          trail_nxt = '0;
          rej_nxt   = 1'b1;
        end
        ITEM_BYTE: begin
          rej_c   = head.entry.start ? 1'b0 : rej_r;
          pos_c   = head.entry.start ? '0 : pos_r;
          offset  = pos_c - (seq0 ? HDR_FIRST : HDR_NEXT);
          pos_nxt = pos_c;
          if (!rej_c) begin
            if (pos_c == POS_W'(0) || pos_c == POS_W'(3)) begin
              hi_nxt = b;
            end else if (pos_c == POS_W'(1)) begin
              if (word != chan_r) rej_c = 1'b1;
            end else if (pos_c == POS_W'(2)) begin
              if (b != tag_r) rej_c = 1'b1;
            end else if (pos_c == POS_W'(4)) begin
              if (word != seq_r) rej_c = 1'b1;
            end else if (seq0 && pos_c == POS_W'(5)) begin
              hi_nxt = b;
            end else if (seq0 && pos_c == POS_W'(6)) begin
              // length word of packet zero; an empty response ends here
              total_nxt = word;
              rcvd_nxt  = '0;
              trail_nxt = '0;
              if (word == 16'd0) begin
                emit                = 1'b1;
                res.last            = 1'b1;
                res.result_code     = RC_SHORT;
                res.response_length = word;
                seq_nxt   = '0;
                total_nxt = '0;
                rej_c     = 1'b1;
              end
            end else if (8'(offset) < cap && rcvd_r < total_r) begin
              emit                = 1'b1;
              res.data_byte       = b;
              res.data_valid      = 1'b1;
              res.response_length = total_r;
              rcvd_nxt            = rcvd_inc;
              trail_nxt           = trail_sh;
              if (rcvd_inc == total_r) begin
                res.last = 1'b1;
                if (total_r < 16'd2) begin
                  res.result_code = RC_SHORT;
                end else begin
                  res.status_word = trail_sh;
                  res.result_code = (trail_sh == SW_OK) ? RC_OK : RC_STATUS;
                end
                seq_nxt   = '0;
                rcvd_nxt  = '0;
                total_nxt = '0;
                trail_nxt = '0;
                rej_c     = 1'b1;
              end
            end
            if (!rej_c) begin
              if (pos_c >= LAST_POS) begin
                seq_nxt = seq_r + 16'd1;
                rej_c   = 1'b1;
              end else begin
                pos_nxt = pos_c + 1'b1;
              end
            end
          end
          rej_nxt = rej_c;
        end
        default: begin
          // hold state for codes the front end never queues
          rej_nxt = rej_r;
        end
      endcase
    end

    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r      <= CHANNEL_ID_RST;
      tag_r       <= APDU_TAG_RST;
      pos_r       <= '0;
      seq_r       <= '0;
      total_r     <= '0;
      rcvd_r      <= '0;
      rej_r       <= 1'b0;
      hi_r        <= '0;
      trail_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHANNEL_ID: chan_r <= cfg_wdata;
          CFG_APDU_TAG:   tag_r  <= cfg_wdata[7:0];
          default:        tag_r  <= tag_r;
        endcase
      end
      pos_r       <= pos_nxt;
      seq_r       <= seq_nxt;
      total_r     <= total_nxt;
      rcvd_r      <= rcvd_nxt;
      rej_r       <= rej_nxt;
      hi_r        <= hi_nxt;
      trail_r     <= trail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.data_byte       = out_r.data_byte;
  assign out_ch.data_valid      = out_r.data_valid;
  assign out_ch.last            = out_r.last;
  assign out_ch.result_code     = out_r.result_code;
  assign out_ch.status_word     = out_r.status_word;
  assign out_ch.response_length = out_r.response_length;

endmodule

[tb/apdu_packet_deframer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// APDU packet deframer testbench
// Streams framed HID report packets, read timeouts and read failures into the
// deframer under random idling and backpressure, and checks every payload byte
// and status result against a cycle-free model of the deframing rules.
// ----------------------------------------------------------------------------
module apdu_packet_deframer_unit_tb;
  import apdf_pkg::*;

  localparam int          CLK_PERIOD   = 8;
  localparam int          PHASE_ITEMS  = 190;   // counted transfers per setting
  localparam int          DRAIN_CYCLES = 8;     // idle time for the queue to drain items with no result
  localparam int          LONG_HOLDOFF = 300;   // receiver stall that fills the queue
  localparam longint      WATCHDOG_NS  = 64'd8_000_000;

  // --------------------------------------------------------------------------
  // Model of the deframer: header checks, capacity, completion and aborts.
  // Holds its own copy of the registers and of the framing state.
  // --------------------------------------------------------------------------
  class apdu_response_tracker;
    result_t     due_results[$];
    int unsigned mismatches;

    logic [15:0] chan_cfg;
    logic [7:0]  tag_cfg;
    logic [6:0]  pos_r;
    logic [15:0] seq_r;
    logic [15:0] total_r;
    logic [15:0] count_r;
    logic        skip_r;
    logic [7:0]  hi_r;
    logic [15:0] tail_r;

    function new();
      chan_cfg   = CHANNEL_ID_RST;
      tag_cfg    = APDU_TAG_RST;
      pos_r      = '0;
      seq_r      = '0;
      total_r    = '0;
      count_r    = '0;
      skip_r     = 1'b0;
      hi_r       = '0;
      tail_r     = '0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] val);
      if (idx == CFG_CHANNEL_ID) chan_cfg = val;
      else tag_cfg = val[7:0];
    endfunction

    function void push_result(logic [7:0] d, logic dv, logic lst, result_code_t rc,
                              logic [15:0] sw);
      result_t r;
      r.data_byte       = d;
      r.data_valid      = dv;
      r.last            = lst;
      r.result_code     = rc;
      r.status_word     = sw;
      r.response_length = total_r;
      due_results.push_back(r);
    endfunction

    // Clear the response and drop the rest of the current packet.
    function void close_response();
      seq_r   = '0;
      count_r = '0;
      total_r = '0;
      tail_r  = '0;
      skip_r  = 1'b1;
    endfunction

    function void complete(logic [7:0] d, logic dv);
      if (total_r < 16'd2) begin
        push_result(d, dv, 1'b1, RC_SHORT, 16'h0000);
      end else if (tail_r == SW_OK) begin
        push_result(d, dv, 1'b1, RC_OK, tail_r);
      end else begin
        push_result(d, dv, 1'b1, RC_STATUS, tail_r);
      end
      close_response();
    endfunction

    function void take_item(req_type_t rt, logic [7:0] b, logic st);
      int  p;
      int  hdr;
      int  cap;
      bit  first_pkt;
      if (rt == REQ_TIMEOUT || rt == REQ_FAIL) begin
        if (rt == REQ_TIMEOUT) push_result(8'h00, 1'b0, 1'b1, RC_TIMEOUT, 16'h0000);
        else push_result(8'h00, 1'b0, 1'b1, RC_READ_FAIL, 16'h0000);
        close_response();
        return;
      end
      if (rt == REQ_NONE) return;
      if (st) begin
        pos_r  = '0;
        skip_r = 1'b0;
      end
      if (skip_r) return;

      p         = int'(pos_r);
      first_pkt = (seq_r == 16'h0000);
      hdr       = first_pkt ? 7 : 5;
      cap       = first_pkt ? APDF_FIRST_CAPACITY : APDF_NEXT_CAPACITY;

      if (p == 0 || p == 3) begin
        hi_r = b;
      end else if (p == 1) begin
        if ({hi_r, b} != chan_cfg) skip_r = 1'b1;
      end else if (p == 2) begin
        if (b != tag_cfg) skip_r = 1'b1;
      end else if (p == 4) begin
        if ({hi_r, b} != seq_r) skip_r = 1'b1;
      end else if (first_pkt && p == 5) begin
        hi_r = b;
      end else if (first_pkt && p == 6) begin
        total_r = {hi_r, b};
        count_r = '0;
        tail_r  = '0;
        if (total_r == 16'h0000) complete(8'h00, 1'b0);
      end else if (p - hdr < cap && count_r < total_r) begin
        count_r = count_r + 16'd1;
        tail_r  = {tail_r[7:0], b};
        if (count_r == total_r) complete(b, 1'b1);
        else push_result(b, 1'b1, 1'b0, RC_BUSY, 16'h0000);
      end

      if (!skip_r) begin
        if (p >= APDF_PACKET_BYTES - 1) begin
          seq_r  = seq_r + 16'd1;
          skip_r = 1'b1;
        end else begin
          pos_r = 7'(p + 1);
        end
      end
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void match_result(logic [7:0] d, logic dv, logic lst, logic [2:0] rc,
                               logic [15:0] sw, logic [15:0] len);
      result_t want;
      if (due_results.size() == 0) begin
        $error("result with none due: data_byte %0h last %0b result_code %0d", d, lst, rc);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      check_field("data_byte",       16'(want.data_byte),   16'(d));
      check_field("data_valid",      16'(want.data_valid),  16'(dv));
      check_field("last",            16'(want.last),        16'(lst));
      check_field("result_code",     16'(want.result_code), 16'(rc));
      check_field("status_word",     want.status_word,      sw);
      check_field("response_length", want.response_length, len);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always #(CLK_PERIOD / 2) clk = ~clk;

  apdf_in_if  in_if ();
  apdf_out_if out_if ();

  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  apdu_packet_deframer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  apdu_response_tracker tracker;

  logic [15:0] cur_chan;
  logic [7:0]  cur_tag;
  logic [7:0]  frame_buf [APDF_PACKET_BYTES];
  logic [7:0]  payload_stream [$];
  int unsigned items_taken;
  bit          sender_burst;
  bit          holdoff_req;

  // --------------------------------------------------------------------------
  // Idle lengths: mostly none, some short, a few long.
  // --------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Response lengths: mostly single packets, capacity edges, some multi-packet,
  // and a few huge ones that can only end in an abort.
  function automatic int unsigned pick_total();
    int unsigned r;
    int unsigned edges [8];
    edges = '{56, 57, 58, 59, 115, 116, 117, 118};
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(0, 3);
    if (r < 45) return $urandom_range(4, 57);
    if (r < 60) return edges[$urandom_range(0, 7)];
    if (r < 85) return $urandom_range(58, 240);
    if (r < 96) return $urandom_range(0, 65535);
    return 65535;
  endfunction

  // --------------------------------------------------------------------------
  // Driving tasks. Inputs change on the falling edge; each task returns on the
  // rising edge at which its transfer happened.
  // --------------------------------------------------------------------------
  task automatic send_item(input req_type_t rt, input logic [7:0] b, input logic st,
                           input bit counts);
    int unsigned gap;
    gap = sender_burst ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.req_type     <= rt;
    in_if.rx_byte      <= b;
    in_if.packet_start <= st;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    tracker.take_item(rt, b, st);
    if (counts) items_taken++;
  endtask

  task automatic send_abort();
    if ($urandom_range(0, 1))
      send_item(REQ_TIMEOUT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    else
      send_item(REQ_FAIL, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  // Send the first n bytes of frame_buf as one packet, with the odd unused
  // request mixed in.
  task automatic send_frame(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 49) == 0)
        send_item(REQ_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
      send_item(REQ_BYTE, frame_buf[i], (i == 0), 1'b1);
    end
  endtask

  task automatic build_frame(input int unsigned s, input int unsigned total,
                             input int unsigned idx, input int unsigned n_pay);
    int unsigned i;
    int unsigned hdr;
    logic [15:0] seq16;
    logic [15:0] len16;
    seq16 = 16'(s);
    len16 = 16'(total);
    hdr   = (s == 0) ? 7 : 5;
    for (i = 0; i < APDF_PACKET_BYTES; i++) frame_buf[i] = 8'($urandom_range(0, 255));
    frame_buf[0] = cur_chan[15:8];
    frame_buf[1] = cur_chan[7:0];
    frame_buf[2] = cur_tag;
    frame_buf[3] = seq16[15:8];
    frame_buf[4] = seq16[7:0];
    if (s == 0) begin
      frame_buf[5] = len16[15:8];
      frame_buf[6] = len16[7:0];
    end
    for (i = 0; i < n_pay; i++) frame_buf[hdr + i] = payload_stream[idx + i];
  endtask

  // One response as a host would see it, with the occasional bad header,
  // cut packet or abort thrown in.
  task automatic send_response(input int unsigned total);
    int unsigned npkts;
    int unsigned nsend;
    int unsigned supplied;
    int unsigned idx;
    int unsigned s;
    int unsigned hdr;
    int unsigned cap;
    int unsigned n_pay;
    int unsigned n;
    int unsigned r;
    int unsigned p;
    int unsigned i;
    int unsigned strays;
    bit          cut_short;
    logic [7:0]  saved;

    npkts = (total <= APDF_FIRST_CAPACITY) ? 1 :
            1 + (total - APDF_FIRST_CAPACITY + APDF_NEXT_CAPACITY - 1) / APDF_NEXT_CAPACITY;
    // Keep huge responses short: two packets, then abort.
    cut_short = (npkts > 4);
    nsend     = cut_short ? 2 : npkts;
    supplied  = cut_short ? APDF_FIRST_CAPACITY + APDF_NEXT_CAPACITY : total;

    payload_stream.delete();
    for (i = 0; i < supplied; i++) payload_stream.push_back(8'($urandom_range(0, 255)));
    if (!cut_short && total >= 2 && $urandom_range(0, 1)) begin
      payload_stream[total - 2] = SW_OK[15:8];
      payload_stream[total - 1] = SW_OK[7:0];
    end
    sender_burst = ($urandom_range(0, 99) < 20);

    idx = 0;
    for (s = 0; s < nsend; s++) begin
      hdr   = (s == 0) ? 7 : 5;
      cap   = (s == 0) ? APDF_FIRST_CAPACITY : APDF_NEXT_CAPACITY;
      n_pay = (supplied - idx < cap) ? supplied - idx : cap;
      build_frame(s, total, idx, n_pay);

      r = $urandom_range(0, 99);
      if (r < 5) begin
        // Bad header byte: the packet is skipped and sent again below.
        p            = $urandom_range(0, 4);
        saved        = frame_buf[p];
        frame_buf[p] = saved ^ 8'($urandom_range(1, 255));
        send_frame(APDF_PACKET_BYTES);
        frame_buf[p] = saved;
      end else if (r < 9) begin
        // Cut packet, then the full one.
        send_frame($urandom_range(1, APDF_PACKET_BYTES - 1));
      end else if (r < 12) begin
        send_frame($urandom_range(1, APDF_PACKET_BYTES - 1));
        send_abort();
        return;
      end

      if (s == nsend - 1 && !cut_short) begin
        // Final packet: the tail after the last payload byte is optional.
        n = ($urandom_range(0, 99) < 30) ? APDF_PACKET_BYTES : hdr + n_pay;
        send_frame(n);
      end else begin
        send_frame(APDF_PACKET_BYTES);
        if ($urandom_range(0, 99) < 15) begin
          strays = $urandom_range(1, 4);
          for (i = 0; i < strays; i++)
            send_item(REQ_BYTE, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
      end
      idx += n_pay;
    end
    if (cut_short) send_abort();
  endtask

  // Unstructured traffic: any request type, any byte, any start flag.
  task automatic send_noise();
    int unsigned n;
    int unsigned i;
    req_type_t   rt;
    n = $urandom_range(1, 8);
    sender_burst = ($urandom_range(0, 99) < 20);
    for (i = 0; i < n; i++) begin
      rt = req_type_t'($urandom_range(0, 3));
      send_item(rt, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), (rt != REQ_NONE));
    end
  endtask

  // Drop valid and hold until every due result has arrived and the queue
  // has had time to drain items that produce nothing.
  task automatic quiesce();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers on back-to-back cycles; cfg_we stays high between.
  task automatic write_config(input logic [15:0] ch, input logic [7:0] tg);
    logic [15:0] tag_word;
    tag_word = {8'($urandom_range(0, 255)), tg};
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CHANNEL_ID;
    cfg_wdata <= ch;
    @(posedge clk);
    tracker.set_reg(CFG_CHANNEL_ID, ch);
    @(negedge clk);
    cfg_index <= CFG_APDU_TAG;
    cfg_wdata <= tag_word;
    @(posedge clk);
    tracker.set_reg(CFG_APDU_TAG, tag_word);
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_chan  = ch;
    cur_tag   = tg;
  endtask

  task automatic run_phase();
    int unsigned goal;
    goal = items_taken + PHASE_ITEMS;
    while (items_taken < goal) begin
      if ($urandom_range(0, 99) < 10) send_noise();
      else send_response(pick_total());
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random ready with runs and stalls, plus one long hold-off
  // on request so that the input queue fills and stalls the sender.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    bit          ready_next;
    int unsigned r;
    hold_left    = 0;
    ready_next   = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLDOFF) @(negedge clk);
        holdoff_req   = 1'b0;
        hold_left     = 0;
        out_if.ready <= 1'b1;
      end else begin
        if (hold_left == 0) begin
          ready_next = ($urandom_range(0, 99) < 70);
          r          = $urandom_range(0, 99);
          if (ready_next) hold_left = (r < 90) ? $urandom_range(1, 40) : $urandom_range(100, 200);
          else if (r < 80) hold_left = $urandom_range(1, 3);
          else if (r < 96) hold_left = $urandom_range(4, 12);
          else hold_left = $urandom_range(20, 60);
        end
        out_if.ready <= ready_next;
        hold_left--;
      end
    end
  end

  // Check every result transfer against the oldest due result.
  always @(posedge clk) begin
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      tracker.match_result(out_if.data_byte, out_if.data_valid, out_if.last,
                           out_if.result_code, out_if.status_word, out_if.response_length);
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #(WATCHDOG_NS);
    $display("** apdu_packet_deframer_unit: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned ph;
    tracker            = new();
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.req_type     = REQ_BYTE;
    in_if.rx_byte      = 8'h00;
    in_if.packet_start = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_CHANNEL_ID;
    cfg_wdata          = '0;
    cur_chan           = CHANNEL_ID_RST;
    cur_tag            = APDU_TAG_RST;
    items_taken        = 0;
    sender_burst       = 1'b0;
    holdoff_req        = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Bytes with no start after reset count as a packet from position 0;
    // then a timeout aborts it.
    send_item(REQ_BYTE, CHANNEL_ID_RST[15:8], 1'b0, 1'b1);
    send_item(REQ_BYTE, CHANNEL_ID_RST[7:0], 1'b0, 1'b1);
    send_item(REQ_BYTE, APDU_TAG_RST, 1'b0, 1'b1);
    send_item(REQ_TIMEOUT, 8'hFF, 1'b0, 1'b1);

    // Zero total length: completes on the last length byte as too short.
    build_frame(0, 0, 0, 0);
    frame_buf[5] = 8'h00;
    send_frame(7);

    // Total length one: single byte with last set, still too short.
    payload_stream.delete();
    payload_stream.push_back(8'hFF);
    build_frame(0, 1, 0, 1);
    send_frame(8);

    // Read failure while idle, and an unused request type.
    send_item(REQ_FAIL, 8'h00, 1'b1, 1'b1);
    send_item(REQ_NONE, 8'hFF, 1'b1, 1'b0);

    // Reset settings first, then the extremes, random values, and back.
    run_phase();
    for (ph = 1; ph <= 5; ph++) begin
      quiesce();
      case (ph)
        1: begin
          write_config(16'h0000, 8'h00);
        end
        2: begin
          write_config(16'hFFFF, 8'hFF);
          holdoff_req = 1'b1;
        end
        5: begin
          write_config(CHANNEL_ID_RST, APDU_TAG_RST);
        end
        default: begin
          write_config(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        end
      endcase
      run_phase();
    end

    quiesce();
    if (tracker.mismatches == 0 && tracker.due_results.size() == 0) begin
      $display("** apdu_packet_deframer_unit: PASSED **");
    end else begin
      if (tracker.due_results.size() != 0)
        $error("%0d results never arrived", tracker.due_results.size());
      $display("** apdu_packet_deframer_unit: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/apdf_pkg.sv
hdl/apdf_in_if.sv
hdl/apdf_out_if.sv
hdl/apdf_front.sv
hdl/apdf_queue.sv
hdl/apdf_core.sv
hdl/apdu_packet_deframer_unit.sv
tb/apdu_packet_deframer_unit_tb.sv
